@@ src/q8sg_pkg.sv @@
package q8sg_pkg;

  localparam int NLANES = 8;
  localparam int VAL_W  = 17;

  localparam logic [VAL_W-1:0] VAL_POS_MAX = 17'd65535;
  localparam logic [VAL_W-1:0] VAL_NEG_MAX = 17'd65536;

  typedef enum logic [1:0] {
    GRP_SHAPE = 2'd0,
    GRP_DXI   = 2'd1,
    GRP_DETA  = 2'd2
  } grp_t;

  typedef enum logic [2:0] {
    K_2F2 = 3'd0,
    K_2F1 = 3'd1,
    K_F2  = 3'd2,
    K_F1  = 3'd3,
    K_F0  = 3'd4
  } kcode_t;

  typedef struct packed {
    logic vld;
    grp_t grp;
    logic last;
  } pipe_ctl_t;

endpackage

@@ src/q8sg_issue.sv @@
module q8sg_issue
  import q8sg_pkg::*;
#(
  parameter int FRAC_BITS = 14
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [31:0]           in_tdata,
  output pipe_ctl_t             ctl_o,
  output logic [FRAC_BITS+1:0]  a_mag [NLANES],
  output logic [FRAC_BITS+1:0]  b_mag [NLANES],
  output logic [FRAC_BITS+1:0]  c_mag [NLANES],
  output logic                  neg [NLANES],
  output kcode_t                kc [NLANES]
);

  localparam int W  = FRAC_BITS + 3;
  localparam int M  = FRAC_BITS + 2;
  localparam int CW = W + 16;

  logic                full_r;
  grp_t                grp_r;
  pipe_ctl_t           ctl_r;
  logic signed [W-1:0] x_r, y_r;

  logic accept, issue;

  logic signed [W-1:0] s_w, one_w, mone_w;
  logic signed [W-1:0] xm, xp, ym, yp, nx, ny, x2, y2;
  logic signed [W-1:0] fa [NLANES];
  logic signed [W-1:0] fb [NLANES];
  logic signed [W-1:0] fc [NLANES];
  kcode_t              fk [NLANES];

  function automatic logic signed [W-1:0] clamp_coord(input logic [15:0] raw);
    logic signed [CW-1:0] v;
    logic signed [CW-1:0] s_c;
    logic signed [CW-1:0] r;
    v   = CW'(signed'(raw));
    s_c = signed'(CW'(1) << FRAC_BITS);
    if (v > s_c) begin
      r = s_c;
    end else if (v < -s_c) begin
      r = -s_c;
    end else begin
      r = v;
    end
    return r[W-1:0];
  endfunction

  function automatic logic [M-1:0] mag_of(input logic signed [W-1:0] v);
    logic [W-1:0] t;
    t = v[W-1] ? (~v + W'(1)) : v;
    return t[M-1:0];
  endfunction

  assign accept    = in_tvalid && in_tready;
  assign issue     = en && full_r;
  assign in_tready = !full_r || (en && (grp_r == GRP_DETA));
  assign ctl_o     = ctl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= 1'b0;
      grp_r  <= GRP_SHAPE;
      ctl_r  <= '0;
    end else begin
      if (accept) begin
        full_r <= 1'b1;
      end else if (issue && (grp_r == GRP_DETA)) begin
        full_r <= 1'b0;
      end
      if (issue) begin
        grp_r <= (grp_r == GRP_DETA) ? GRP_SHAPE : grp_t'(grp_r + 2'd1);
      end
      if (en) begin
        ctl_r.vld  <= full_r;
        ctl_r.grp  <= grp_r;
        ctl_r.last <= (grp_r == GRP_DETA);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x_r <= clamp_coord(in_tdata[15:0]);
      y_r <= clamp_coord(in_tdata[31:16]);
    end
  end

  assign s_w    = signed'(W'(1) << FRAC_BITS);
  assign one_w  = signed'(W'(1));
  assign mone_w = -one_w;
  assign xm     = s_w - x_r;
  assign xp     = s_w + x_r;
  assign ym     = s_w - y_r;
  assign yp     = s_w + y_r;
  assign nx     = -x_r;
  assign ny     = -y_r;
  assign x2     = x_r <<< 1;
  assign y2     = y_r <<< 1;

  always_comb begin
    for (int j = 0; j < NLANES; j++) begin
      fa[j] = one_w;
      fb[j] = one_w;
      fc[j] = one_w;
      fk[j] = K_F0;
    end
    case (grp_r)
      GRP_SHAPE: begin
        fa[0] = xm; fb[0] = ym; fc[0] = -s_w - x_r - y_r; fk[0] = K_2F2;
        fa[1] = xp; fb[1] = ym; fc[1] = -s_w + x_r - y_r; fk[1] = K_2F2;
        fa[2] = xp; fb[2] = yp; fc[2] = -s_w + x_r + y_r; fk[2] = K_2F2;
        fa[3] = xm; fb[3] = yp; fc[3] = -s_w - x_r + y_r; fk[3] = K_2F2;
        fa[4] = xm; fb[4] = xp; fc[4] = ym;               fk[4] = K_2F1;
        fa[5] = xp; fb[5] = ym; fc[5] = yp;               fk[5] = K_2F1;
        fa[6] = xm; fb[6] = xp; fc[6] = yp;               fk[6] = K_2F1;
        fa[7] = xm; fb[7] = ym; fc[7] = yp;               fk[7] = K_2F1;
      end
      GRP_DXI: begin
        fa[0] = ym; fb[0] = x2 + y_r; fk[0] = K_F2;
        fa[1] = ym; fb[1] = x2 - y_r; fk[1] = K_F2;
        fa[2] = yp; fb[2] = x2 + y_r; fk[2] = K_F2;
        fa[3] = yp; fb[3] = x2 - y_r; fk[3] = K_F2;
        fa[4] = nx; fb[4] = ym;       fk[4] = K_F0;
        fa[5] = ym; fb[5] = yp;       fk[5] = K_F1;
        fa[6] = nx; fb[6] = yp;       fk[6] = K_F0;
        fa[7] = ym; fb[7] = yp; fc[7] = mone_w; fk[7] = K_F1;
      end
      GRP_DETA: begin
        fa[0] = xm; fb[0] = y2 + x_r; fk[0] = K_F2;
        fa[1] = xp; fb[1] = y2 - x_r; fk[1] = K_F2;
        fa[2] = xp; fb[2] = y2 + x_r; fk[2] = K_F2;
        fa[3] = xm; fb[3] = y2 - x_r; fk[3] = K_F2;
        fa[4] = xm; fb[4] = xp; fc[4] = mone_w; fk[4] = K_F1;
        fa[5] = ny; fb[5] = xp;       fk[5] = K_F0;
        fa[6] = xm; fb[6] = xp;       fk[6] = K_F1;
        fa[7] = ny; fb[7] = xm;       fk[7] = K_F0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < NLANES; j++) begin
        a_mag[j] <= mag_of(fa[j]);
        b_mag[j] <= mag_of(fb[j]);
        c_mag[j] <= mag_of(fc[j]);
        neg[j]   <= fa[j][W-1] ^ fb[j][W-1] ^ fc[j][W-1];
        kc[j]    <= fk[j];
      end
    end
  end

endmodule

@@ src/q8sg_lane.sv @@
module q8sg_lane
  import q8sg_pkg::*;
#(
  parameter int FRAC_BITS = 14
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic [FRAC_BITS+1:0]  a_mag,
  input  logic [FRAC_BITS+1:0]  b_mag,
  input  logic [FRAC_BITS+1:0]  c_mag,
  input  logic                  neg,
  input  kcode_t                kc,
  output logic [VAL_W-1:0]      val
);

  localparam int M  = FRAC_BITS + 2;
  localparam int PW = 3 * M + 1;

  logic [2*M-1:0]   m1_r;
  logic [M-1:0]     c2_r;
  logic             neg2_r, neg3_r, neg4_r;
  kcode_t           k2_r, k3_r, k4_r;
  logic [2*M-1:0]   pplo_r, pphi_r;
  logic [PW-1:0]    sum_r;
  logic [VAL_W-1:0] val_r;

  logic [PW-1:0]    rnd;
  logic [PW-1:0]    q;
  logic [VAL_W-1:0] lim;
  logic [VAL_W-1:0] qv;

  always_comb begin
    case (k3_r)
      K_2F2:   rnd = PW'(1) << (2 * FRAC_BITS + 1);
      K_2F1:   rnd = PW'(1) << (2 * FRAC_BITS);
      K_F2:    rnd = PW'(1) << (FRAC_BITS + 1);
      K_F1:    rnd = PW'(1) << FRAC_BITS;
      K_F0:    rnd = PW'(1) << (FRAC_BITS - 1);
      default: rnd = '0;
    endcase
  end

  always_comb begin
    case (k4_r)
      K_2F2:   q = sum_r >> (2 * FRAC_BITS + 2);
      K_2F1:   q = sum_r >> (2 * FRAC_BITS + 1);
      K_F2:    q = sum_r >> (FRAC_BITS + 2);
      K_F1:    q = sum_r >> (FRAC_BITS + 1);
      K_F0:    q = sum_r >> FRAC_BITS;
      default: q = '0;
    endcase
    lim = neg4_r ? VAL_NEG_MAX : VAL_POS_MAX;
    qv  = (q > PW'(lim)) ? lim : q[VAL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_r   <= a_mag * b_mag;
      c2_r   <= c_mag;
      neg2_r <= neg;
      k2_r   <= kc;

      pplo_r <= m1_r[M-1:0] * c2_r;
      pphi_r <= m1_r[2*M-1:M] * c2_r;
      neg3_r <= neg2_r;
      k3_r   <= k2_r;

      sum_r  <= PW'({pphi_r, M'(0)}) + PW'(pplo_r) + rnd;
      neg4_r <= neg3_r;
      k4_r   <= k3_r;

      val_r  <= neg4_r ? (~qv + VAL_W'(1)) : qv;
    end
  end

  assign val = val_r;

endmodule

@@ src/quad8_shape_and_gradient_eval_core.sv @@
// Channel  Dir  Ports                         Beat contents (lowest bits first)
// in       in   in_tvalid/tready/tdata        xi[15:0], eta[31:16]
// out      out  out_tvalid/tready/tdata/      value_0..value_7, 17 bits each;
//               tuser/tlast                   tuser = group, tlast on third beat
//
// Each input beat yields three output beats; the single output port carries
// one group per cycle unless out_tready stalls. A new input is taken when none
// is held or as the held one issues its third group. Registered stages: operand
// select, a*b, partial products by c, sum and round, shift and saturate.
// Synchronous active-low reset clears the valid bits and the group counter.
// A stall on out_tready freezes every stage; one input beat is held meanwhile.
module quad8_shape_and_gradient_eval_core
  import q8sg_pkg::*;
#(
  parameter int FRAC_BITS = 14
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [31:0]               in_tdata,   // xi, eta
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [NLANES*VAL_W-1:0]   out_tdata,  // value_0 .. value_7
  output logic [1:0]                out_tuser,  // group
  output logic                      out_tlast
);

  localparam int M = FRAC_BITS + 2;

  logic      en;
  pipe_ctl_t c1;
  pipe_ctl_t c2_r, c3_r, c4_r, c5_r;

  logic [M-1:0]     a_mag [NLANES];
  logic [M-1:0]     b_mag [NLANES];
  logic [M-1:0]     c_mag [NLANES];
  logic             neg   [NLANES];
  kcode_t           kc    [NLANES];
  logic [VAL_W-1:0] val   [NLANES];

  assign en = !c5_r.vld || out_tready;

  q8sg_issue #(
    .FRAC_BITS (FRAC_BITS)
  ) u_issue (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .ctl_o     (c1),
    .a_mag     (a_mag),
    .b_mag     (b_mag),
    .c_mag     (c_mag),
    .neg       (neg),
    .kc        (kc)
  );

  for (genvar j = 0; j < NLANES; j++) begin : g_lane
    q8sg_lane #(
      .FRAC_BITS (FRAC_BITS)
    ) u_lane (
      .clk   (clk),
      .en    (en),
      .a_mag (a_mag[j]),
      .b_mag (b_mag[j]),
      .c_mag (c_mag[j]),
      .neg   (neg[j]),
      .kc    (kc[j]),
      .val   (val[j])
    );
    assign out_tdata[j*VAL_W +: VAL_W] = val[j];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c2_r <= '0;
      c3_r <= '0;
      c4_r <= '0;
      c5_r <= '0;
    end else if (en) begin
      c2_r <= c1;
      c3_r <= c2_r;
      c4_r <= c3_r;
      c5_r <= c4_r;
    end
  end

  assign out_tvalid = c5_r.vld;
  assign out_tuser  = c5_r.grp;
  assign out_tlast  = c5_r.last;

endmodule

@@ dv/q8sg_shape_checker.sv @@
module q8sg_shape_checker
  import q8sg_pkg::*;
#(
  parameter int FRAC_BITS = 14
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_tvalid,
  input  logic                    in_tready,
  input  logic [31:0]             in_tdata,
  input  logic                    out_tvalid,
  input  logic                    out_tready,
  input  logic [NLANES*VAL_W-1:0] out_tdata,
  input  logic [1:0]              out_tuser,
  input  logic                    out_tlast,
  output int                      fail_count,
  output int                      pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SH_CORNER = 2 * FRAC_BITS + 2;
  localparam int unsigned SH_MID    = 2 * FRAC_BITS + 1;
  localparam int unsigned SH_QUART  = FRAC_BITS + 2;
  localparam int unsigned SH_HALF   = FRAC_BITS + 1;
  localparam int unsigned SH_UNIT   = FRAC_BITS;

  typedef struct packed {
    grp_t                         grp;
    logic [NLANES-1:0][VAL_W-1:0] val;
    logic                         last;
  } lane_beat_t;

  lane_beat_t lane_beats_q[$];
  int         mism = 0;

  // round(a*b*c / 2^k) to nearest, ties away from zero, clipped to 17 bits signed
  function automatic logic [VAL_W-1:0] scaled_prod(longint a, longint b, longint c,
                                                    int unsigned k);
    logic         neg;
    logic [127:0] ma;
    logic [127:0] mb;
    logic [127:0] mc;
    logic [127:0] mag;
    logic [127:0] lim;
    neg = (a < 0) ^ (b < 0) ^ (c < 0);
    ma  = (a < 0) ? 128'(-a) : 128'(a);
    mb  = (b < 0) ? 128'(-b) : 128'(b);
    mc  = (c < 0) ? 128'(-c) : 128'(c);
    mag = ma * mb * mc;
    mag = (mag + (128'd1 << (k - 1))) >> k;
    lim = neg ? 128'(VAL_NEG_MAX) : 128'(VAL_POS_MAX);
    if (mag > lim) mag = lim;
    return neg ? -mag[VAL_W-1:0] : mag[VAL_W-1:0];
  endfunction

  function automatic longint clamp_coord(logic [15:0] raw);
    longint v;
    longint s;
    s = longint'(1) << FRAC_BITS;
    v = longint'(signed'(raw));
    if (v > s) v = s;
    if (v < -s) v = -s;
    return v;
  endfunction

  function automatic void predict_shape(logic [31:0] coords);
    longint     s;
    longint     x;
    longint     y;
    longint     xm;
    longint     xp;
    longint     ym;
    longint     yp;
    lane_beat_t nv;
    lane_beat_t dx;
    lane_beat_t dy;
    s  = longint'(1) << FRAC_BITS;
    x  = clamp_coord(coords[15:0]);
    y  = clamp_coord(coords[31:16]);
    xm = s - x;
    xp = s + x;
    ym = s - y;
    yp = s + y;

    nv.grp    = GRP_SHAPE;
    nv.last   = 1'b0;
    nv.val[0] = scaled_prod(xm, ym, -s - x - y, SH_CORNER);
    nv.val[1] = scaled_prod(xp, ym, -s + x - y, SH_CORNER);
    nv.val[2] = scaled_prod(xp, yp, -s + x + y, SH_CORNER);
    nv.val[3] = scaled_prod(xm, yp, -s - x + y, SH_CORNER);
    nv.val[4] = scaled_prod(xm, xp, ym, SH_MID);
    nv.val[5] = scaled_prod(xp, ym, yp, SH_MID);
    nv.val[6] = scaled_prod(xm, xp, yp, SH_MID);
    nv.val[7] = scaled_prod(xm, ym, yp, SH_MID);

    dx.grp    = GRP_DXI;
    dx.last   = 1'b0;
    dx.val[0] = scaled_prod(ym, 2 * x + y, 1, SH_QUART);
    dx.val[1] = scaled_prod(ym, 2 * x - y, 1, SH_QUART);
    dx.val[2] = scaled_prod(yp, 2 * x + y, 1, SH_QUART);
    dx.val[3] = scaled_prod(yp, 2 * x - y, 1, SH_QUART);
    dx.val[4] = scaled_prod(-x, ym, 1, SH_UNIT);
    dx.val[5] = scaled_prod(ym, yp, 1, SH_HALF);
    dx.val[6] = scaled_prod(-x, yp, 1, SH_UNIT);
    dx.val[7] = scaled_prod(ym, yp, -1, SH_HALF);

    dy.grp    = GRP_DETA;
    dy.last   = 1'b1;
    dy.val[0] = scaled_prod(xm, 2 * y + x, 1, SH_QUART);
    dy.val[1] = scaled_prod(xp, 2 * y - x, 1, SH_QUART);
    dy.val[2] = scaled_prod(xp, 2 * y + x, 1, SH_QUART);
    dy.val[3] = scaled_prod(xm, 2 * y - x, 1, SH_QUART);
    dy.val[4] = scaled_prod(xm, xp, -1, SH_HALF);
    dy.val[5] = scaled_prod(-y, xp, 1, SH_UNIT);
    dy.val[6] = scaled_prod(xm, xp, 1, SH_HALF);
    dy.val[7] = scaled_prod(-y, xm, 1, SH_UNIT);

    lane_beats_q.push_back(nv);
    lane_beats_q.push_back(dx);
    lane_beats_q.push_back(dy);
  endfunction

  always @(posedge clk) begin
    lane_beat_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (lane_beats_q.size() == 0) begin
          $display("%0t unexpected beat: group %0d data %h last %b", $time,
                   out_tuser, out_tdata, out_tlast);
          mism++;
        end else begin
          want = lane_beats_q.pop_front();
          if (out_tuser !== want.grp) begin
            $display("%0t group mismatch: expected %0d got %0d", $time, want.grp, out_tuser);
            mism++;
          end
          for (int lane = 0; lane < NLANES; lane++) begin
            if (out_tdata[lane*VAL_W +: VAL_W] !== want.val[lane]) begin
              $display("%0t group %0d value_%0d mismatch: expected %h got %h", $time,
                       want.grp, lane, want.val[lane], out_tdata[lane*VAL_W +: VAL_W]);
              mism++;
            end
          end
          if (out_tlast !== want.last) begin
            $display("%0t group %0d last mismatch: expected %b got %b", $time,
                     want.grp, want.last, out_tlast);
            mism++;
          end
        end
      end
      if (in_tvalid && in_tready) predict_shape(in_tdata);
    end
    fail_count <= mism;
    pending    <= lane_beats_q.size();
  end

endmodule

@@ dv/testbench.sv @@
module testbench
  import q8sg_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC_BITS  = 14;
  localparam int ONE        = 1 << FRAC_BITS;
  localparam int IDLE_LIMIT = 4000;
  localparam int HOLD_LEN   = 300;

  logic                    clk = 1'b0;
  logic                    rst_n;
  logic                    in_tvalid;
  logic                    in_tready;
  logic [31:0]             in_tdata;   // xi[15:0], eta[31:16]
  logic                    out_tvalid;
  logic                    out_tready;
  logic [NLANES*VAL_W-1:0] out_tdata;  // value_0 .. value_7, 17 bits each
  logic [1:0]              out_tuser;  // group
  logic                    out_tlast;

  int fail_count;
  int pending;
  int idle_cycles = 0;
  bit no_gaps     = 1'b0;
  bit hold_req    = 1'b0;

  always #10 clk = ~clk;

  quad8_shape_and_gradient_eval_core #(
    .FRAC_BITS(FRAC_BITS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  q8sg_shape_checker #(
    .FRAC_BITS(FRAC_BITS)
  ) shape_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .fail_count(fail_count),
    .pending   (pending)
  );

  task automatic send_coord(input int xi, input int eta);
    if (!no_gaps) begin
      while ($urandom_range(99) < 13) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {eta[15:0], xi[15:0]};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // receiver: random backpressure, one long hold-off on request
  initial begin
    int  hold;
    bit  hold_done;
    hold       = 0;
    hold_done  = 1'b0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold      = HOLD_LEN;
      end
      if (hold > 0) begin
        hold--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= no_gaps || ($urandom_range(99) >= 13);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("%0t timeout: no beat for %0d cycles, %0d results pending", $time,
               IDLE_LIMIT, pending);
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int xi;
    int eta;
    int pick;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // center, corner nodes, mid-edge nodes
    send_coord(0, 0);
    send_coord(-ONE, -ONE);
    send_coord(ONE, -ONE);
    send_coord(ONE, ONE);
    send_coord(-ONE, ONE);
    send_coord(0, -ONE);
    send_coord(ONE, 0);
    send_coord(0, ONE);
    send_coord(-ONE, 0);
    // out-of-range coordinates clip to the element boundary; -1 and 65535 both read as -1
    send_coord(-32768, 32767);
    send_coord(32767, -32768);
    send_coord(ONE + 1, -ONE - 1);
    send_coord(-1, -1);
    send_coord(65535, 65535);
    // fine steps and rounding ties
    send_coord(1, 1);
    send_coord(-1, 1);
    send_coord(1, -3);
    send_coord(ONE / 2, ONE / 2);
    send_coord(-ONE / 2, 3 * ONE / 4);
    send_coord(ONE - 1, -ONE + 1);
    send_coord(-ONE + 1, ONE - 1);
    send_coord(16'h5555, 16'hAAAA);

    for (int n = 0; n < 440; n++) begin
      no_gaps = (n >= 100 && n < 180);
      if (n == 260) hold_req = 1'b1;
      pick = $urandom_range(99);
      if (pick < 8) begin
        xi  = $urandom_range(65535);
        eta = $urandom_range(65535);
      end else if (pick < 18) begin
        xi  = $urandom_range(1) ? ONE - $urandom_range(3) : $urandom_range(3) - ONE;
        eta = $urandom_range(1) ? ONE - $urandom_range(3) : $urandom_range(3) - ONE;
      end else begin
        xi  = $urandom_range(2 * ONE) - ONE;
        eta = $urandom_range(2 * ONE) - ONE;
      end
      send_coord(xi, eta);
    end
    no_gaps = 1'b0;
    in_tvalid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
